// ----- hdl/afk_pkg.sv -----
// afk_pkg: shared widths, constants and types for the arm forward kinematics unit
// no dependencies
`default_nettype none
package afk_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 18;
  localparam int LEN_BITS = 14;
  localparam int OFF_BITS = 15;
  localparam int IDX_BITS = 3;
  localparam int DATA_BITS = 16;

  localparam logic [34:0] PHASE_MUL = 35'd10937044410;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [31:0] A1 = 32'd1686629714;
  localparam logic [31:0] A3 = 32'd693598670;
  localparam logic [31:0] A5 = 32'd85569306;
  localparam logic [31:0] A7 = 32'd5026996;
  localparam logic [31:0] A9 = 32'd172272;

  typedef enum logic [IDX_BITS-1:0] {
    REG_UPPER = 3'd0,
    REG_FORE  = 3'd1,
    REG_HAND  = 3'd2,
    REG_EOFF  = 3'd3,
    REG_WOFF  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]        upper;
    logic [LEN_BITS-1:0]        fore;
    logic [LEN_BITS-1:0]        hand;
    logic signed [OFF_BITS-1:0] eoff;
    logic signed [OFF_BITS-1:0] woff;
  } cfg_t;
endpackage
`default_nettype wire

// ----- hdl/afk_sine.sv -----
// afk_sine: pipelined polynomial sine of a 32-bit turn phase, Q30 result
// depends on afk_pkg; advances when en is high
`default_nettype none
module afk_sine import afk_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [31:0]        phase,
  output logic signed [31:0]      sine
);
  // stage regs carry u (31b), w, negate flag and the running value
  logic [30:0] u [6];
  logic        neg [7];
  logic [30:0] w [4];
  logic [31:0] p3, p5, p7, p9;
  logic [31:0] pf;

  logic [29:0] f0;
  logic [61:0] sq;
  logic [62:0] m1, m2, m3, m4, m5;
  assign f0 = phase[29:0];
  assign sq = u[0] * u[0];
  assign m1 = w[0] * A9;
  assign m2 = w[1] * p9;
  assign m3 = w[2] * p7;
  assign m4 = w[3] * p5;
  assign m5 = {32'd0, u[5]} * {31'd0, p3};

  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= phase[30] ? (Q30_ONE - {1'b0, f0}) : {1'b0, f0};
      neg[0] <= phase[31];
      for (int i = 1; i < 6; i++) u[i] <= u[i-1];
      for (int i = 1; i < 7; i++) neg[i] <= neg[i-1];
      // u can be exactly one, so w keeps bit 30
      w[0] <= sq[60:30];
      for (int i = 1; i < 4; i++) w[i] <= w[i-1];
      p9 <= A7 - m1[61:30];
      p7 <= A5 - m2[61:30];
      p5 <= A3 - m3[61:30];
      p3 <= A1 - m4[61:30];
      pf <= m5[61:30];
      sine <= neg[6] ? -$signed(pf) : $signed(pf);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/afk_regs.sv -----
// afk_regs: configuration register file with write channel
// depends on afk_pkg
`default_nettype none
module afk_regs import afk_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IDX_BITS-1:0]  cfg_index,
  input  wire logic [DATA_BITS-1:0] cfg_data,
  output cfg_t                      cfg
);
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper <= LEN_BITS'(1638);
      cfg.fore <= LEN_BITS'(1638);
      cfg.hand <= LEN_BITS'(819);
      cfg.eoff <= '0;
      cfg.woff <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER: cfg.upper <= cfg_data[LEN_BITS-1:0];
        REG_FORE:  cfg.fore <= cfg_data[LEN_BITS-1:0];
        REG_HAND:  cfg.hand <= cfg_data[LEN_BITS-1:0];
        REG_EOFF:  cfg.eoff <= cfg_data[OFF_BITS-1:0];
        REG_WOFF:  cfg.woff <= cfg_data[OFF_BITS-1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/arm_forward_kinematics_unit.sv -----
// arm_forward_kinematics_unit: top level, phase stage, eight sine pipes, link and output stages
// depends on afk_pkg, afk_regs, afk_sine
//
// usage: joint angles enter on in_valid/in_stall, one transfer per cycle while in_stall is low.
// results leave on out_valid/out_stall, one per input, in order.
// pipeline: 14 register stages (1 phase stage, 8 sine stages, 5 link and
// rotation stages); out_valid travels with the data in a matching valid
// shift register.
// throughput: one item per cycle while out_stall does not hold the last stage; set by the fully pipelined datapath.
// the whole pipeline advances when the output is empty or taken; in_stall
// is high exactly when the last stage holds a result that out_stall blocks.
// configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is
// always high. write only while the pipeline is empty.
// reset: rst clears all valid bits and loads the default link lengths.
// a stalled result holds its value until taken.
`default_nettype none
module arm_forward_kinematics_unit import afk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [ANGLE_BITS-1:0] base_angle,
  input  wire logic signed [ANGLE_BITS-1:0] shoulder_angle,
  input  wire logic signed [ANGLE_BITS-1:0] elbow_angle,
  input  wire logic signed [ANGLE_BITS-1:0] wrist_angle,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [IDX_BITS-1:0]  cfg_index,
  input  wire logic [DATA_BITS-1:0] cfg_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [COORD_BITS-1:0] elbow_x,
  output logic signed [COORD_BITS-1:0] elbow_height,
  output logic signed [COORD_BITS-1:0] elbow_depth,
  output logic signed [COORD_BITS-1:0] wrist_x,
  output logic signed [COORD_BITS-1:0] wrist_height,
  output logic signed [COORD_BITS-1:0] wrist_depth,
  output logic signed [COORD_BITS-1:0] claw_x,
  output logic signed [COORD_BITS-1:0] claw_height,
  output logic signed [COORD_BITS-1:0] claw_depth
);
  localparam int DEPTH = 14;
  localparam int SW = ANGLE_BITS + 2;
  cfg_t cfg;
  logic en;
  logic [DEPTH-1:0] vld;

  afk_regs u_regs (.clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg);

  assign en = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // phase stage
  logic signed [SW-1:0] pe, pw;
  logic signed [SW-1:0] ang [4];
  logic [31:0] ph [4];
  logic [31:0] phr [6];
  always_comb begin
    pe = SW'(shoulder_angle) + SW'(elbow_angle);
    pw = pe + SW'(wrist_angle);
    ang[0] = SW'(base_angle);
    ang[1] = SW'(shoulder_angle);
    ang[2] = pe;
    ang[3] = pw;
    for (int i = 0; i < 4; i++) begin
      logic signed [SW+35:0] pr;
      pr = $signed({{36{ang[i][SW-1]}}, ang[i]}) * $signed({1'b0, PHASE_MUL});
      ph[i] = pr[47:16];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      phr[0] <= ph[0] + 32'h4000_0000;
      phr[1] <= ph[0];
      phr[2] <= ph[1] + 32'h4000_0000;
      phr[3] <= ph[1];
      phr[4] <= ph[2] + 32'h4000_0000;
      phr[5] <= ph[2];
    end
  end
  // wrist pitch needs its own pair
  logic [31:0] phw_c, phw_s;
  always_ff @(posedge clk) begin
    if (en) begin
      phw_c <= ph[3] + 32'h4000_0000;
      phw_s <= ph[3];
    end
  end

  logic signed [31:0] tr [8];
  for (genvar g = 0; g < 6; g++) begin : g_sin
    afk_sine u_sin (.clk, .en, .phase(phr[g]), .sine(tr[g]));
  end
  afk_sine u_sin_wc (.clk, .en, .phase(phw_c), .sine(tr[6]));
  afk_sine u_sin_ws (.clk, .en, .phase(phw_s), .sine(tr[7]));

  // link stage A: link terms, Q15
  logic signed [47:0] lp [6];
  logic signed [35:0] lt [6];
  logic signed [31:0] ct1, st1;
  always_comb begin
    lp[0] = $signed({1'b0, cfg.upper}) * tr[2];
    lp[1] = $signed({1'b0, cfg.upper}) * tr[3];
    lp[2] = $signed({1'b0, cfg.fore}) * tr[4];
    lp[3] = $signed({1'b0, cfg.fore}) * tr[5];
    lp[4] = $signed({1'b0, cfg.hand}) * tr[6];
    lp[5] = $signed({1'b0, cfg.hand}) * tr[7];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) lt[i] <= 36'((lp[i] + 48'sd16384) >>> 15);
      ct1 <= tr[0];
      st1 <= tr[1];
    end
  end

  // stage B: chain sums
  logic signed [37:0] r1, z1, r2, z2, r3, z3;
  logic signed [31:0] ct2, st2;
  logic signed [OFF_BITS:0] eo, to;
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= 38'(lt[0]);
      z1 <= 38'(lt[1]);
      r2 <= 38'(lt[0]) + 38'(lt[2]);
      z2 <= 38'(lt[1]) + 38'(lt[3]);
      r3 <= 38'(lt[0]) + 38'(lt[2]) + 38'(lt[4]);
      z3 <= 38'(lt[1]) + 38'(lt[3]) + 38'(lt[5]);
      ct2 <= ct1;
      st2 <= st1;
      eo <= (OFF_BITS+1)'(cfg.eoff);
      to <= (OFF_BITS+1)'(cfg.eoff) + (OFF_BITS+1)'(cfg.woff);
    end
  end

  // stage C: products (32x38 and 16x32 split across fixed paths)
  logic signed [69:0] hx [3], hd [3];
  logic signed [47:0] ox [3], od [3];
  logic signed [37:0] zc [3];
  always_ff @(posedge clk) begin
    if (en) begin
      hx[0] <= r1 * ct2;  hd[0] <= r1 * st2;
      hx[1] <= r2 * ct2;  hd[1] <= r2 * st2;
      hx[2] <= r3 * ct2;  hd[2] <= r3 * st2;
      ox[0] <= -(eo * st2); od[0] <= eo * ct2;
      ox[1] <= -(to * st2); od[1] <= to * ct2;
      ox[2] <= -(to * st2); od[2] <= to * ct2;
      zc[0] <= z1; zc[1] <= z2; zc[2] <= z3;
    end
  end

  // stage D: sum and round
  logic signed [71:0] sx [3], sd [3];
  logic signed [37:0] zd [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= 72'(hx[i]) + (72'(ox[i]) <<< 15) + (72'sd1 <<< 44);
        sd[i] <= 72'(hd[i]) + (72'(od[i]) <<< 15) + (72'sd1 <<< 44);
        zd[i] <= (zc[i] + 38'sd16384) >>> 15;
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [71:0] v);
    logic signed [71:0] hi, lo;
    hi = (72'sd1 <<< (COORD_BITS-1)) - 72'sd1;
    lo = -(72'sd1 <<< (COORD_BITS-1));
    if (v > hi) sat = hi[COORD_BITS-1:0];
    else if (v < lo) sat = lo[COORD_BITS-1:0];
    else sat = v[COORD_BITS-1:0];
  endfunction

  // stage E: saturate into output regs
  always_ff @(posedge clk) begin
    if (en) begin
      elbow_x <= sat(sx[0] >>> 45);
      elbow_depth <= sat(sd[0] >>> 45);
      elbow_height <= sat(72'(zd[0]));
      wrist_x <= sat(sx[1] >>> 45);
      wrist_depth <= sat(sd[1] >>> 45);
      wrist_height <= sat(72'(zd[1]));
      claw_x <= sat(sx[2] >>> 45);
      claw_depth <= sat(sd[2] >>> 45);
      claw_height <= sat(72'(zd[2]));
    end
  end
endmodule
`default_nettype wire

// ----- hdl/afk_checker.sv -----
// afk_checker: port-level assertions for arm_forward_kinematics_unit
// depends on afk_pkg; bound to the top level
`default_nettype none
module afk_checker import afk_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic cfg_ready,
  input wire logic signed [COORD_BITS-1:0] claw_x
);
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)) else $error("stall without full output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(claw_x))) else $error("result lost");
  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("cfg not ready");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule
bind arm_forward_kinematics_unit afk_checker u_chk (.clk, .rst, .in_stall,
  .out_valid, .out_stall, .cfg_ready, .claw_x);
`default_nettype wire
